[src/aff_pkg.sv]
// ----------------------------------------------------------------------------
// aff_pkg
// Shared types and constants of the ASCII frame field parser: byte codes,
// report kinds, register addresses and the frame record between modules.
// ----------------------------------------------------------------------------
package aff_pkg;

  // Start bytes of a frame
  localparam logic [7:0] CHAR_GT   = 8'h3E;  // '>'
  localparam logic [7:0] CHAR_E    = 8'h45;  // 'E'
  localparam logic [7:0] CHAR_D    = 8'h44;  // 'D'
  localparam logic [7:0] CHAR_BANG = 8'h21;  // '!'

  // Command bytes
  localparam logic [7:0] CHAR_EQ = 8'h3D;    // '='
  localparam logic [7:0] CHAR_R  = 8'h52;    // 'R'

  // Digit range and the ignored filler byte
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [7:0] CHAR_NUL   = 8'h00;

  // Register addresses with a report kind of their own
  localparam logic [7:0] ADDR_MIN        = 8'd11;
  localparam logic [7:0] ADDR_MAX        = 8'd12;
  localparam logic [7:0] ADDR_AUDIO      = 8'd17;
  localparam logic [7:0] ADDR_TWO_BUTTON = 8'd18;

  // Report kinds
  localparam logic [3:0] KIND_RAW         = 4'd0;
  localparam logic [3:0] KIND_MIN         = 4'd1;
  localparam logic [3:0] KIND_MAX         = 4'd2;
  localparam logic [3:0] KIND_AUDIO       = 4'd3;
  localparam logic [3:0] KIND_TWO_BUTTON  = 4'd4;
  localparam logic [3:0] KIND_OTHER       = 4'd5;
  localparam logic [3:0] KIND_ERROR       = 4'd6;
  localparam logic [3:0] KIND_BAD_CONTROL = 4'd7;
  localparam logic [3:0] KIND_UNKNOWN     = 4'd8;

  // Saturation ceiling of a digit run
  localparam logic [15:0] RUN_MAX = 16'hFFFF;

  // Finished frame as seen by the classifier and the result register
  typedef struct packed {
    logic        done;
    logic [7:0]  control_code;
    logic [7:0]  command_code;
    logic [15:0] value;
    logic [7:0]  address;
  } frame_t;

endpackage

[src/aff_in_if.sv]
// ----------------------------------------------------------------------------
// aff_in_if
// Byte channel into the parser: valid/ready handshake with one received byte.
// ----------------------------------------------------------------------------
interface aff_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

[src/aff_out_if.sv]
// ----------------------------------------------------------------------------
// aff_out_if
// Report channel out of the parser: valid/ready handshake with one report.
// ----------------------------------------------------------------------------
interface aff_out_if;
  logic        valid;
  logic        ready;
  logic [3:0]  report_kind;
  logic [15:0] value;
  logic [7:0]  address;
  logic [7:0]  control_code;
  logic [7:0]  command_code;

  modport source (output valid, output report_kind, output value, output address,
                  output control_code, output command_code, input ready);
  modport sink   (input valid, input report_kind, input value, input address,
                  input control_code, input command_code, output ready);
endinterface

[src/aff_frame_tracker.sv]
// ----------------------------------------------------------------------------
// aff_frame_tracker
// Frame state machine: hunts the start byte, takes the command byte and
// accumulates two saturating decimal runs. Flags the frame as done on the
// byte that ends the second run.
// ----------------------------------------------------------------------------
module aff_frame_tracker (
  input  logic            clk,
  input  logic            rst,
  input  logic            advance,
  input  logic [7:0]      rx_byte,
  output aff_pkg::frame_t frame
);

  typedef enum logic [1:0] {
    HUNT       = 2'd0,
    COMMAND    = 2'd1,
    FIRST_RUN  = 2'd2,
    SECOND_RUN = 2'd3
  } field_t;

  field_t      field_index;
  field_t      field_index_next;
  logic [7:0]  control_store;
  logic [7:0]  control_store_next;
  logic [7:0]  command_store;
  logic [7:0]  command_store_next;
  logic [15:0] value_store;
  logic [15:0] value_store_next;
  logic [15:0] digit_accumulator;
  logic [15:0] digit_accumulator_next;

  logic        is_start;
  logic        is_digit;
  logic        is_nul;
  logic [19:0] acc_scaled;
  logic [15:0] acc_sat;
  logic        run_end;

  // Classify the incoming byte
  assign is_start = rx_byte inside {aff_pkg::CHAR_GT, aff_pkg::CHAR_E,
                                    aff_pkg::CHAR_D, aff_pkg::CHAR_BANG};
  assign is_digit = rx_byte inside {[aff_pkg::DIGIT_ZERO:aff_pkg::DIGIT_NINE]};
  assign is_nul   = (rx_byte == aff_pkg::CHAR_NUL);
  assign run_end  = !is_digit && !is_nul;

  // acc * 10 + digit as 8x + 2x + d, then clamp
  assign acc_scaled = {1'b0, digit_accumulator, 3'b000}
                    + {3'b000, digit_accumulator, 1'b0}
                    + {16'h0000, rx_byte[3:0]};
  assign acc_sat    = (acc_scaled[19:16] != 4'h0) ? aff_pkg::RUN_MAX : acc_scaled[15:0];

  // Next state of the frame
  always_comb begin
    field_index_next       = field_index;
    control_store_next     = control_store;
    command_store_next     = command_store;
    value_store_next       = value_store;
    digit_accumulator_next = digit_accumulator;
    case (field_index)
      HUNT: begin
        if (is_start) begin
          control_store_next = rx_byte;
          field_index_next   = COMMAND;
        end
      end
      COMMAND: begin
        command_store_next = rx_byte;
        field_index_next   = FIRST_RUN;
      end
      FIRST_RUN: begin
        if (is_digit) begin
          digit_accumulator_next = acc_sat;
        end else if (run_end) begin
          value_store_next       = digit_accumulator;
          digit_accumulator_next = 16'h0000;
          field_index_next       = SECOND_RUN;
        end
      end
      SECOND_RUN: begin
        if (is_digit) begin
          digit_accumulator_next = acc_sat;
        end else if (run_end) begin
          digit_accumulator_next = 16'h0000;
          field_index_next       = HUNT;
        end
      end
      default: begin
        field_index_next = HUNT;
      end
    endcase
  end

  // Hold frame state; advance only on a byte taken by the core
  always_ff @(posedge clk) begin
    if (rst) begin
      field_index       <= HUNT;
      control_store     <= 8'h00;
      command_store     <= 8'h00;
      value_store       <= 16'h0000;
      digit_accumulator <= 16'h0000;
    end else if (advance) begin
      field_index       <= field_index_next;
      control_store     <= control_store_next;
      command_store     <= command_store_next;
      value_store       <= value_store_next;
      digit_accumulator <= digit_accumulator_next;
    end
  end

  // Report the finished frame with the fields as they stand
  assign frame.done         = (field_index == SECOND_RUN) && run_end;
  assign frame.control_code = control_store;
  assign frame.command_code = command_store;
  assign frame.value        = value_store;
  assign frame.address      = digit_accumulator[7:0];

endmodule

[src/aff_classifier.sv]
// ----------------------------------------------------------------------------
// aff_classifier
// Maps a finished frame to its report kind from the control byte, the
// command byte and the register address.
// ----------------------------------------------------------------------------
module aff_classifier (
  input  aff_pkg::frame_t frame,
  output logic [3:0]      report_kind
);

  logic [3:0] reg_kind;

  // Pick the kind of a register read by address
  always_comb begin
    case (frame.address)
      aff_pkg::ADDR_MIN:        reg_kind = aff_pkg::KIND_MIN;
      aff_pkg::ADDR_MAX:        reg_kind = aff_pkg::KIND_MAX;
      aff_pkg::ADDR_AUDIO:      reg_kind = aff_pkg::KIND_AUDIO;
      aff_pkg::ADDR_TWO_BUTTON: reg_kind = aff_pkg::KIND_TWO_BUTTON;
      default:                  reg_kind = aff_pkg::KIND_OTHER;
    endcase
  end

  // Bad control byte wins, then the command decides
  always_comb begin
    if (frame.control_code != aff_pkg::CHAR_GT) begin
      report_kind = aff_pkg::KIND_BAD_CONTROL;
    end else begin
      case (frame.command_code)
        aff_pkg::CHAR_EQ: report_kind = aff_pkg::KIND_RAW;
        aff_pkg::CHAR_R:  report_kind = reg_kind;
        aff_pkg::CHAR_E:  report_kind = aff_pkg::KIND_ERROR;
        default:          report_kind = aff_pkg::KIND_UNKNOWN;
      endcase
    end
  end

endmodule

[src/ascii_frame_field_parser.sv]
// ----------------------------------------------------------------------------
// ascii_frame_field_parser
// Parses framed ASCII replies byte by byte and emits one classified report
// per complete frame.
// ----------------------------------------------------------------------------
// The parser takes one received byte per clock unless report back-pressure
// holds it, and never stalls on its own: a byte is captured in an input
// register, the frame tracker and classifier act on it as it advances from
// there, and a report, when the byte closes a frame, is loaded into the output
// register as that byte advances. While a report waits to be taken the input
// accepts one more byte into the empty input register; it holds only when the
// output register is full and not being drained and a byte is already waiting
// in the input register. A frame is a start byte ('>', 'E', 'D' or '!'), any
// command byte, then two decimal runs each closed by a non-digit byte; NUL
// bytes inside a run are skipped and runs saturate at 65535. Address is the
// low byte of the second run.
module ascii_frame_field_parser (
  input  logic      clk,
  input  logic      rst,
  aff_in_if.sink    rx,
  aff_out_if.source report
);

  logic            s1_valid;
  logic [7:0]      s1_byte;
  logic            advance;
  aff_pkg::frame_t frame;
  logic [3:0]      frame_kind;

  logic            out_valid;
  logic [3:0]      out_kind;
  logic [15:0]     out_value;
  logic [7:0]      out_address;
  logic [7:0]      out_control;
  logic [7:0]      out_command;

  // Process the held byte when the result register is free or draining
  assign advance  = s1_valid && (!out_valid || report.ready);
  assign rx.ready = !s1_valid || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (rx.ready) begin
      s1_valid <= rx.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rx.valid && rx.ready) begin
      s1_byte <= rx.rx_byte;
    end
  end

  aff_frame_tracker u_tracker (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .rx_byte (s1_byte),
    .frame   (frame)
  );

  aff_classifier u_classifier (
    .frame       (frame),
    .report_kind (frame_kind)
  );

  // Result register: load on a closing byte, drop after the transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= frame.done;
    end else if (report.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && frame.done) begin
      out_kind    <= frame_kind;
      out_value   <= frame.value;
      out_address <= frame.address;
      out_control <= frame.control_code;
      out_command <= frame.command_code;
    end
  end

  assign report.valid        = out_valid;
  assign report.report_kind  = out_kind;
  assign report.value        = out_value;
  assign report.address      = out_address;
  assign report.control_code = out_control;
  assign report.command_code = out_command;

  // An empty input register always takes a byte
  a_empty_ready : assert property (@(posedge clk) disable iff (rst)
    !s1_valid |-> rx.ready)
    else $error("input register empty but not ready");

  // A waiting byte is processed whenever no report is pending
  a_byte_advances : assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !out_valid) |-> advance)
    else $error("byte held with free result register");

  // A report never carries a kind outside the defined set
  a_kind_range : assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_kind <= aff_pkg::KIND_UNKNOWN))
    else $error("report kind out of range");

  // Only frames started by '>' classify below the bad-control kind
  a_good_control : assert property (@(posedge clk) disable iff (rst)
    (out_valid && (out_kind < aff_pkg::KIND_BAD_CONTROL))
      |-> (out_control == aff_pkg::CHAR_GT))
    else $error("report kind disagrees with control byte");

endmodule
